// ----- design/vssg_pkg.sv -----
// vssg_pkg: shared types, register indexes, reset values and clamp helper
// for the velocity servo session gate; no dependencies
package vssg_pkg;

  localparam int VelW   = 16;
  localparam int LimW   = 15;
  localparam int TimeW  = 32;
  localparam int IdW    = 16;
  localparam int MsW    = 16;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] REG_MOTION_ID = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_TIMEOUT   = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_RETRY     = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_LIMIT_X   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_LIMIT_Y   = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_LIMIT_TURN = 3'd5;

  localparam logic [IdW-1:0]  RST_MOTION_ID  = 16'd303;
  localparam logic [MsW-1:0]  RST_TIMEOUT    = 16'd250;
  localparam logic [MsW-1:0]  RST_RETRY      = 16'd500;
  localparam logic [LimW-1:0] RST_LIMIT_X    = 15'd1229;
  localparam logic [LimW-1:0] RST_LIMIT_Y    = 15'd819;
  localparam logic [LimW-1:0] RST_LIMIT_TURN = 15'd3277;

  typedef enum logic [1:0] {
    OP_VEL    = 2'd0,
    OP_CTRL   = 2'd1,
    OP_STATUS = 2'd2,
    OP_TICK   = 2'd3
  } op_e_t;

  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_DATA  = 2'd1,
    KIND_END   = 2'd2
  } kind_e_t;

  typedef struct packed {
    logic [IdW-1:0]  mode_id;
    logic [MsW-1:0]  timeout;
    logic [MsW-1:0]  retry;
    logic [LimW-1:0] lim_x;
    logic [LimW-1:0] lim_y;
    logic [LimW-1:0] lim_turn;
  } cfg_t;

  typedef struct packed {
    op_e_t                  op;
    logic [TimeW-1:0]       now_ms;
    logic signed [VelW-1:0] vel_x;
    logic signed [VelW-1:0] vel_y;
    logic signed [VelW-1:0] vel_turn;
    logic                   valid_flag;
    logic [IdW-1:0]         status_motion_id;
    logic                   switch_ok;
  } item_t;

  typedef struct packed {
    kind_e_t                cmd_kind;
    logic [IdW-1:0]         mode_id;
    logic signed [VelW-1:0] x;
    logic signed [VelW-1:0] y;
    logic signed [VelW-1:0] turn;
  } result_t;

  function automatic logic signed [VelW-1:0] clamp_sym(
    input logic signed [VelW-1:0] v,
    input logic [LimW-1:0]        lim
  );
    logic signed [VelW:0] v_w;
    logic signed [VelW:0] lim_w;
    logic signed [VelW:0] neg_w;
    logic signed [VelW-1:0] r;
    v_w   = {v[VelW-1], v};
    lim_w = signed'({2'b00, lim});
    neg_w = -lim_w;
    if (v_w > lim_w) begin
      r = lim_w[VelW-1:0];
    end else if (v_w < neg_w) begin
      r = neg_w[VelW-1:0];
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ----- design/vssg_in_if.sv -----
// vssg_in_if: input item channel, valid/ready with item payload
// depends on nothing
interface vssg_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [31:0] now_ms;
  logic signed [15:0] vel_x;
  logic signed [15:0] vel_y;
  logic signed [15:0] vel_turn;
  logic        valid_flag;
  logic [15:0] status_motion_id;
  logic        switch_ok;

  modport source (
    output valid, op, now_ms, vel_x, vel_y, vel_turn, valid_flag,
           status_motion_id, switch_ok,
    input  ready
  );
  modport sink (
    input  valid, op, now_ms, vel_x, vel_y, vel_turn, valid_flag,
           status_motion_id, switch_ok,
    output ready
  );
endinterface

// ----- design/vssg_out_if.sv -----
// vssg_out_if: result channel, valid/ready with command payload
// depends on nothing
interface vssg_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd_kind;
  logic [15:0] out_motion_id;
  logic signed [15:0] out_x;
  logic signed [15:0] out_y;
  logic signed [15:0] out_turn;

  modport source (
    output valid, cmd_kind, out_motion_id, out_x, out_y, out_turn,
    input  ready
  );
  modport sink (
    input  valid, cmd_kind, out_motion_id, out_x, out_y, out_turn,
    output ready
  );
endinterface

// ----- design/vssg_cfg_if.sv -----
// vssg_cfg_if: configuration write channel, register index and data
// depends on nothing
interface vssg_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- design/velocity_servo_session_gate.sv -----
// velocity_servo_session_gate: input register, session core, result register
// an accepted item is held in the input register, and any result from the core is
// held in the result register; one transaction per cycle while the output is not stalled
// synchronous active-low reset clears session flags, pipeline valids and
// restores configuration defaults
module velocity_servo_session_gate (
  input  logic        clk,
  input  logic        rst_n,
  vssg_in_if.sink     in_ch,
  vssg_out_if.source  out_ch,
  vssg_cfg_if.sink    cfg_ch
);

  logic              in_vld_r, in_vld_nxt;
  vssg_pkg::item_t   in_item_r, in_item_nxt;
  logic              out_vld_r, out_vld_nxt;
  vssg_pkg::result_t out_res_r, out_res_nxt;
  logic              core_fire;
  logic              res_vld;
  vssg_pkg::result_t res;
  vssg_pkg::cfg_t    cfg;

  assign core_fire    = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready  = !in_vld_r || core_fire;
  assign cfg_ch.ready = 1'b1;

  vssg_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_ch.valid),
    .wr_index (cfg_ch.index),
    .wr_data  (cfg_ch.data),
    .cfg      (cfg)
  );

  vssg_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (core_fire),
    .item    (in_item_r),
    .cfg     (cfg),
    .res_vld (res_vld),
    .res     (res)
  );

  always_comb begin
    in_vld_nxt  = in_vld_r;
    in_item_nxt = in_item_r;
    if (in_ch.valid && in_ch.ready) begin
      in_vld_nxt                   = 1'b1;
      in_item_nxt.op               = vssg_pkg::op_e_t'(in_ch.op);
      in_item_nxt.now_ms           = in_ch.now_ms;
      in_item_nxt.vel_x            = in_ch.vel_x;
      in_item_nxt.vel_y            = in_ch.vel_y;
      in_item_nxt.vel_turn         = in_ch.vel_turn;
      in_item_nxt.valid_flag       = in_ch.valid_flag;
      in_item_nxt.status_motion_id = in_ch.status_motion_id;
      in_item_nxt.switch_ok        = in_ch.switch_ok;
    end else if (core_fire) begin
      in_vld_nxt = 1'b0;
    end
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    out_res_nxt = out_res_r;
    if (core_fire) begin
      out_vld_nxt = res_vld;
      if (res_vld) begin
        out_res_nxt = res;
      end
    end else if (out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_item_r <= in_item_nxt;
    out_res_r <= out_res_nxt;
  end

  assign out_ch.valid         = out_vld_r;
  assign out_ch.cmd_kind      = out_res_r.cmd_kind;
  assign out_ch.out_motion_id = out_res_r.mode_id;
  assign out_ch.out_x         = out_res_r.x;
  assign out_ch.out_y         = out_res_r.y;
  assign out_ch.out_turn      = out_res_r.turn;

`ifndef SYNTHESIS
  a_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && (out_res_r.cmd_kind == vssg_pkg::KIND_END) |->
      (out_res_r.x == '0) && (out_res_r.y == '0) && (out_res_r.turn == '0))
    else $error("end transaction carries nonzero velocity");

  a_x_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |->
      ($signed({out_res_r.x[15], out_res_r.x}) <= $signed({2'b00, cfg.lim_x})) &&
      ($signed({out_res_r.x[15], out_res_r.x}) >= -$signed({2'b00, cfg.lim_x})))
    else $error("forward speed outside clamp");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && !core_fire |=> in_vld_r && $stable(in_item_r))
    else $error("held input transaction lost or changed");
`endif

endmodule

// ----- design/vssg_cfg_regs.sv -----
// vssg_cfg_regs: configuration register file with reset values
// depends on vssg_pkg
module vssg_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            wr_en,
  input  logic [vssg_pkg::CfgIdxW-1:0]    wr_index,
  input  logic [vssg_pkg::CfgDataW-1:0]   wr_data,
  output vssg_pkg::cfg_t                  cfg
);

  vssg_pkg::cfg_t cfg_r;
  vssg_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        vssg_pkg::REG_MOTION_ID:  cfg_nxt.mode_id   = wr_data;
        vssg_pkg::REG_TIMEOUT:    cfg_nxt.timeout   = wr_data;
        vssg_pkg::REG_RETRY:      cfg_nxt.retry     = wr_data;
        vssg_pkg::REG_LIMIT_X:    cfg_nxt.lim_x     = wr_data[vssg_pkg::LimW-1:0];
        vssg_pkg::REG_LIMIT_Y:    cfg_nxt.lim_y     = wr_data[vssg_pkg::LimW-1:0];
        vssg_pkg::REG_LIMIT_TURN: cfg_nxt.lim_turn  = wr_data[vssg_pkg::LimW-1:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode_id   <= vssg_pkg::RST_MOTION_ID;
      cfg_r.timeout   <= vssg_pkg::RST_TIMEOUT;
      cfg_r.retry     <= vssg_pkg::RST_RETRY;
      cfg_r.lim_x     <= vssg_pkg::RST_LIMIT_X;
      cfg_r.lim_y     <= vssg_pkg::RST_LIMIT_Y;
      cfg_r.lim_turn  <= vssg_pkg::RST_LIMIT_TURN;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- design/vssg_core.sv -----
// vssg_core: session state, freshness check, clamps and result selection
// depends on vssg_pkg
module vssg_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  vssg_pkg::item_t   item,
  input  vssg_pkg::cfg_t    cfg,
  output logic              res_vld,
  output vssg_pkg::result_t res
);

  logic have_cmd_r, have_cmd_nxt;
  logic ctrl_valid_r, ctrl_valid_nxt;
  logic session_r, session_nxt;
  logic ready_r, ready_nxt;
  logic start_set_r, start_set_nxt;
  logic signed [vssg_pkg::VelW-1:0] vel_x_r, vel_x_nxt;
  logic signed [vssg_pkg::VelW-1:0] vel_y_r, vel_y_nxt;
  logic signed [vssg_pkg::VelW-1:0] vel_turn_r, vel_turn_nxt;
  logic [vssg_pkg::TimeW-1:0] cmd_time_r, cmd_time_nxt;
  logic [vssg_pkg::TimeW-1:0] start_time_r, start_time_nxt;

  logic [vssg_pkg::TimeW-1:0] cmd_age;
  logic [vssg_pkg::TimeW-1:0] start_age;
  logic fresh;
  logic retry_due;
  logic signed [vssg_pkg::VelW-1:0] sel_x, sel_y, sel_turn;

  assign cmd_age   = item.now_ms - cmd_time_r;
  assign start_age = item.now_ms - start_time_r;
  assign fresh     = have_cmd_r && (cmd_age <= {16'd0, cfg.timeout});
  assign retry_due = !start_set_r || (start_age >= {16'd0, cfg.retry});
  assign sel_x     = fresh ? vel_x_r    : '0;
  assign sel_y     = fresh ? vel_y_r    : '0;
  assign sel_turn  = fresh ? vel_turn_r : '0;

  always_comb begin
    have_cmd_nxt   = have_cmd_r;
    ctrl_valid_nxt = ctrl_valid_r;
    session_nxt    = session_r;
    ready_nxt      = ready_r;
    start_set_nxt  = start_set_r;
    vel_x_nxt      = vel_x_r;
    vel_y_nxt      = vel_y_r;
    vel_turn_nxt   = vel_turn_r;
    cmd_time_nxt   = cmd_time_r;
    start_time_nxt = start_time_r;
    res_vld        = 1'b0;
    res.cmd_kind   = vssg_pkg::KIND_DATA;
    res.mode_id    = cfg.mode_id;
    res.x          = vssg_pkg::clamp_sym(sel_x, cfg.lim_x);
    res.y          = vssg_pkg::clamp_sym(sel_y, cfg.lim_y);
    res.turn       = vssg_pkg::clamp_sym(sel_turn, cfg.lim_turn);
    if (fire) begin
      unique case (item.op)
        vssg_pkg::OP_VEL: begin
          vel_x_nxt    = item.vel_x;
          vel_y_nxt    = item.vel_y;
          vel_turn_nxt = item.vel_turn;
          cmd_time_nxt = item.now_ms;
          have_cmd_nxt = 1'b1;
        end
        vssg_pkg::OP_CTRL: begin
          ctrl_valid_nxt = item.valid_flag;
        end
        vssg_pkg::OP_STATUS: begin
          ready_nxt = (item.status_motion_id == cfg.mode_id) && item.switch_ok;
        end
        vssg_pkg::OP_TICK: begin
          if (!ctrl_valid_r && session_r) begin
            res_vld        = 1'b1;
            res.cmd_kind   = vssg_pkg::KIND_END;
            res.x          = '0;
            res.y          = '0;
            res.turn       = '0;
            session_nxt    = 1'b0;
            ready_nxt      = 1'b0;
            start_set_nxt  = 1'b0;
            start_time_nxt = '0;
          end else if (ctrl_valid_r) begin
            res_vld = 1'b1;
            if (!session_r || (!ready_r && retry_due)) begin
              res.cmd_kind   = vssg_pkg::KIND_START;
              start_time_nxt = item.now_ms;
              start_set_nxt  = 1'b1;
            end
            session_nxt = 1'b1;
          end
        end
        default: begin
          have_cmd_nxt = have_cmd_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_cmd_r   <= 1'b0;
      ctrl_valid_r <= 1'b0;
      session_r    <= 1'b0;
      ready_r      <= 1'b0;
      start_set_r  <= 1'b0;
    end else begin
      have_cmd_r   <= have_cmd_nxt;
      ctrl_valid_r <= ctrl_valid_nxt;
      session_r    <= session_nxt;
      ready_r      <= ready_nxt;
      start_set_r  <= start_set_nxt;
    end
  end

  // payload, only read once the matching flag is set
  always_ff @(posedge clk) begin
    vel_x_r      <= vel_x_nxt;
    vel_y_r      <= vel_y_nxt;
    vel_turn_r   <= vel_turn_nxt;
    cmd_time_r   <= cmd_time_nxt;
    start_time_r <= start_time_nxt;
  end

endmodule
